/* hdl/mdiom_pkg.sv */
// Shared types and constants for the MDIO management frame master.
package mdiom_pkg;

    localparam int DATA_BITS    = 16;
    localparam int FRAME_BITS   = 32;
    localparam int PRE_W        = 6;
    localparam int POS_W        = 7;
    localparam int ADDR_W       = 5;

    localparam logic [PRE_W-1:0] MAX_PREAMBLE   = 6'd32;
    localparam logic [PRE_W-1:0] PREAMBLE_RESET = 6'd32;

    localparam logic [1:0] HDR_START = 2'b01;
    localparam logic [1:0] OP_READ   = 2'b10;
    localparam logic [1:0] OP_WRITE  = 2'b01;
    localparam logic [1:0] TA_WRITE  = 2'b10;

    // First turnaround slot and first data slot of a frame, counted after the preamble
    localparam logic [4:0] Q_TURN = 5'd14;
    localparam logic [4:0] Q_DATA = 5'd16;
    localparam logic [4:0] Q_LAST = 5'd31;

    localparam int          PADDR_W      = 3;
    localparam logic [0:0]  REG_PREAMBLE = 1'b0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_IDLE    = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [ADDR_W-1:0]    phy_address;
        logic [ADDR_W-1:0]    register_address;
        logic [DATA_BITS-1:0] write_data;
        logic                 mdio_in;
    } req_t;

    typedef struct packed {
        logic                 mdio_out;
        logic                 mdio_drive;
        logic                 bit_slot;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_data;
        logic                 busy_res;
        status_t              status;
    } res_t;

endpackage

/* hdl/mdio_management_frame_master.sv */
// Top level of the Clause 22 MDIO management frame master.
// An accepted request is held in the input register; when the result register is free or
// being taken, its result is loaded there, and the master side takes it from there.
// Throughput: one request per cycle while the master side does not hold m_tready low.
// Reset: rst_n clears the frame state, both stage valids and read data, and sets
// the preamble length register to 32.
module mdio_management_frame_master
    import mdiom_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,  // phy_address, register_address, write_data, mdio_in
    input  logic [1:0]         s_tuser,  // command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,  // mdio_out, mdio_drive, bit_slot, read_data, busy_res
    output logic [1:0]         m_tuser,  // status
    output logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [PRE_W-1:0] preamble_reg;
    logic             cfg_write;

    req_t req_in;
    req_t req;
    res_t res_comb;
    res_t res;
    logic in_valid;
    logic out_valid;
    logic fire;
    logic accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_PREAMBLE);
    assign prdata    = (paddr[PADDR_W-1] == REG_PREAMBLE) ? {26'd0, preamble_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg <= PREAMBLE_RESET;
        end
        else if (cfg_write)
        begin
            preamble_reg <= pwdata[PRE_W-1:0];
        end
    end

    assign req_in.command          = s_tuser;
    assign req_in.phy_address      = s_tdata[4:0];
    assign req_in.register_address = s_tdata[9:5];
    assign req_in.write_data       = s_tdata[25:10];
    assign req_in.mdio_in          = s_tdata[26];

    assign fire     = in_valid && (!out_valid || m_tready);
    assign s_tready = !in_valid || fire;
    assign accept   = s_tvalid && s_tready;

    mdiom_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .take   (fire),
        .req_in (req_in),
        .valid  (in_valid),
        .req    (req)
    );

    mdiom_frame_engine u_frame_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .req           (req),
        .preamble_bits (preamble_reg),
        .res           (res_comb)
    );

    mdiom_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire),
        .res_in (res_comb),
        .taken  (m_tready),
        .valid  (out_valid),
        .res    (res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {4'd0, res.busy_res, res.read_data, res.bit_slot,
                       res.mdio_drive, res.mdio_out};
    assign m_tuser  = res.status;
    assign m_tlast  = res.done_res;

endmodule

/* hdl/mdiom_in_stage.sv */
// Input register holding one accepted request.
module mdiom_in_stage
    import mdiom_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic take,
    input  req_t req_in,
    output logic valid,
    output req_t req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_in;
        end
    end

    assign valid = valid_reg;
    assign req   = req_reg;

endmodule

/* hdl/mdiom_frame_engine.sv */
// Frame state and per-request bit logic of the MDIO master.
module mdiom_frame_engine
    import mdiom_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  req_t             req,
    input  logic [PRE_W-1:0] preamble_bits,
    output res_t             res
);

    logic                  busy_reg, busy_next;
    logic                  is_read_reg, is_read_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [DATA_BITS-1:0]  capture_reg, capture_next;

    logic [PRE_W-1:0] pre;
    logic [POS_W-1:0] q_full;
    logic [4:0]       q;
    logic             is_start;

    always_comb
    begin
        pre      = (preamble_bits > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_bits;
        q_full   = pos_reg - {1'b0, pre};
        q        = (q_full >= POS_W'(Q_LAST)) ? Q_LAST : q_full[4:0];
        is_start = (req.command == CMD_READ) || (req.command == CMD_WRITE);

        busy_next    = busy_reg;
        is_read_next = is_read_reg;
        pos_next     = pos_reg;
        shift_next   = shift_reg;
        capture_next = capture_reg;

        res.mdio_out   = 1'b0;
        res.mdio_drive = 1'b0;
        res.bit_slot   = 1'b0;
        res.done_res   = 1'b0;
        res.status     = ST_OK;

        if (is_start)
        begin
            if (busy_reg)
            begin
                res.status = ST_REFUSED;
            end
            else
            begin
                shift_next = {HDR_START,
                              (req.command == CMD_READ) ? OP_READ : OP_WRITE,
                              req.phy_address, req.register_address, 18'd0};
                if (req.command == CMD_WRITE)
                begin
                    shift_next[17:0] = {TA_WRITE, req.write_data};
                end
                is_read_next = (req.command == CMD_READ);
                pos_next     = '0;
                busy_next    = 1'b1;
            end
        end
        else if (!busy_reg)
        begin
            res.status = ST_IDLE;
        end
        else
        begin
            res.bit_slot = 1'b1;
            if (pos_reg < {1'b0, pre})
            begin
                res.mdio_out   = 1'b1;
                res.mdio_drive = 1'b1;
            end
            else
            begin
                res.done_res = (q_full >= POS_W'(Q_LAST));
                if (is_read_reg && (q >= Q_TURN))
                begin
                    if (q >= Q_DATA)
                    begin
                        capture_next = {capture_reg[DATA_BITS-2:0], req.mdio_in};
                    end
                end
                else
                begin
                    res.mdio_drive = 1'b1;
                    res.mdio_out   = shift_reg[Q_LAST - q];
                end
            end
            if (res.done_res)
            begin
                busy_next = 1'b0;
                pos_next  = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end

        res.read_data = capture_next;
        res.busy_res  = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            is_read_reg <= 1'b0;
            pos_reg     <= '0;
            shift_reg   <= '0;
            capture_reg <= '0;
        end
        else if (fire)
        begin
            busy_reg    <= busy_next;
            is_read_reg <= is_read_next;
            pos_reg     <= pos_next;
            shift_reg   <= shift_next;
            capture_reg <= capture_next;
        end
    end

    a_done_is_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.done_res) |-> res.bit_slot)
        else $error("frame end without a bit period");

    a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !res.mdio_drive) |-> !res.mdio_out)
        else $error("released line driven high");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.done_res) |=> !busy_reg)
        else $error("master still busy after frame end");

    a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.status == ST_REFUSED) |-> busy_reg)
        else $error("start refused while idle");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_start && !busy_reg) |=> (busy_reg && pos_reg == '0))
        else $error("accepted start did not arm a frame");

endmodule

/* hdl/mdiom_out_stage.sv */
// Result register on the master-side stream.
module mdiom_out_stage
    import mdiom_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    input  logic taken,
    output logic valid,
    output res_t res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

/* test/mdio_management_frame_master_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Clause 22 MDIO management frame master.
module mdio_management_frame_master_tb;
    import mdiom_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // frame state tracked alongside the block
    logic [PRE_W-1:0]     pre_len;
    logic                 frm_busy;
    logic                 frm_read;
    logic [POS_W-1:0]     frm_pos;
    logic [31:0]          frm_shift;
    logic [DATA_BITS-1:0] rd_capture;

    res_t pending_results[$];

    int error_count;
    int sender_gap_pct;
    int stall_pct;
    int hold_left;
    int ok_requests;
    int reads_done;
    int writes_done;
    int refused_starts;
    int idle_ticks;
    int results_checked;

    mdio_management_frame_master u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic res_t mdio_frame_step(input logic [1:0] cmd, input logic [4:0] phy,
                                             input logic [4:0] reg_num,
                                             input logic [15:0] wdat, input logic din);
        res_t             r;
        logic [PRE_W-1:0] eff;
        logic [POS_W-1:0] q;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_READ || cmd == CMD_WRITE)
        begin
            if (frm_busy)
                r.status = ST_REFUSED;
            else
            begin
                frm_read  = (cmd == CMD_READ);
                frm_shift = {HDR_START, (frm_read ? OP_READ : OP_WRITE), phy, reg_num, 18'd0};
                if (!frm_read)
                    frm_shift[17:0] = {TA_WRITE, wdat};
                frm_pos  = '0;
                frm_busy = 1'b1;
            end
        end
        else if (!frm_busy)
            r.status = ST_IDLE;
        else
        begin
            eff = (pre_len > MAX_PREAMBLE) ? MAX_PREAMBLE : pre_len;
            r.bit_slot = 1'b1;
            if (frm_pos < {1'b0, eff})
            begin
                r.mdio_out   = 1'b1;
                r.mdio_drive = 1'b1;
            end
            else
            begin
                q = frm_pos - {1'b0, eff};
                if (q >= POS_W'(Q_LAST))
                begin
                    q = POS_W'(Q_LAST);
                    r.done_res = 1'b1;
                end
                if (frm_read && q >= POS_W'(Q_TURN))
                begin
                    if (q >= POS_W'(Q_DATA))
                        rd_capture = {rd_capture[DATA_BITS-2:0], din};
                end
                else
                begin
                    r.mdio_drive = 1'b1;
                    r.mdio_out   = frm_shift[Q_LAST - q[4:0]];
                end
            end
            if (r.done_res)
            begin
                frm_busy = 1'b0;
                frm_pos  = '0;
            end
            else
                frm_pos = frm_pos + POS_W'(1);
        end
        r.read_data = rd_capture;
        r.busy_res  = frm_busy;
        return r;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [4:0] phy,
                                input logic [4:0] reg_num, input logic [15:0] wdat,
                                input logic din);
        res_t r;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, din, wdat, reg_num, phy};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = mdio_frame_step(cmd, phy, reg_num, wdat, din);
        pending_results.push_back(r);
        if (r.status == ST_OK)
            ok_requests++;
        if (r.status == ST_REFUSED)
            refused_starts++;
        if (r.status == ST_IDLE)
            idle_ticks++;
        if (r.done_res && frm_read)
            reads_done++;
        if (r.done_res && !frm_read)
            writes_done++;
    endtask

    task automatic send_tick(input logic [1:0] cmd);
        send_request(cmd, 5'($urandom), 5'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // write the preamble length, then read it back
    task automatic set_preamble(input logic [PRE_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PREAMBLE, 2'b00};
        pwdata  <= {26'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pre_len = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {26'd0, value})
        begin
            $error("preamble_bits: expected %0d, got %0d", value, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic finish_frame();
        while (frm_busy)
            send_tick(($urandom_range(9) == 0) ? CMD_UNUSED : CMD_TICK);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // result checker
    initial
    begin
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result arrived with none outstanding");
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    check_field("mdio_out", want.mdio_out, m_tdata[0]);
                    check_field("mdio_drive", want.mdio_drive, m_tdata[1]);
                    check_field("bit_slot", want.bit_slot, m_tdata[2]);
                    check_field("read_data", want.read_data, m_tdata[18:3]);
                    check_field("busy_res", want.busy_res, m_tdata[19]);
                    check_field("done_res", want.done_res, m_tlast);
                    check_field("status", want.status, m_tuser);
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic test_idle_commands();
        send_tick(CMD_TICK);
        send_request(CMD_UNUSED, 5'd31, 5'd31, 16'hFFFF, 1'b1);
        send_request(CMD_TICK, 5'd0, 5'd0, 16'h0000, 1'b0);
        wait_for_results();
    endtask

    task automatic test_write_frame();
        set_preamble(6'd0);
        send_request(CMD_WRITE, 5'd31, 5'd0, 16'hFFFF, 1'b1);
        send_request(CMD_READ, 5'd0, 5'd31, 16'h0000, 1'b0);
        send_request(CMD_UNUSED, 5'd0, 5'd0, 16'h0000, 1'b1);
        send_request(CMD_WRITE, 5'd0, 5'd0, 16'h0000, 1'b0);
        finish_frame();
        wait_for_results();
        set_preamble(6'd1);
        send_request(CMD_WRITE, 5'd0, 5'd31, 16'h0000, 1'b0);
        finish_frame();
        wait_for_results();
    endtask

    task automatic test_read_frame();
        set_preamble(6'd63);
        send_request(CMD_READ, 5'd0, 5'd31, 16'hA5A5, 1'b1);
        finish_frame();
        wait_for_results();
        set_preamble(6'd32);
        send_request(CMD_READ, 5'd31, 5'd0, 16'h5A5A, 1'b0);
        finish_frame();
        wait_for_results();
    endtask

    task automatic test_preamble_change();
        // shorten the preamble while inside it: jump into the read data
        set_preamble(6'd32);
        send_request(CMD_READ, 5'd21, 5'd10, 16'h1234, 1'b0);
        repeat (20) send_tick(CMD_TICK);
        wait_for_results();
        set_preamble(6'd0);
        finish_frame();
        wait_for_results();
        // shorten it past the end of the frame: next tick ends it
        set_preamble(6'd32);
        send_request(CMD_WRITE, 5'd10, 5'd21, 16'hBEEF, 1'b1);
        repeat (40) send_tick(CMD_TICK);
        wait_for_results();
        set_preamble(6'd0);
        send_tick(CMD_TICK);
        wait_for_results();
        // lengthen it mid-frame: preamble ones again
        set_preamble(6'd5);
        send_request(CMD_WRITE, 5'd3, 5'd7, 16'hC33C, 1'b0);
        repeat (10) send_tick(CMD_TICK);
        wait_for_results();
        set_preamble(6'd63);
        finish_frame();
        wait_for_results();
    endtask

    task automatic test_backpressure();
        sender_gap_pct = 0;
        stall_pct      = 0;
        set_preamble(6'd4);
        hold_left = 60;
        send_request(CMD_READ, 5'($urandom), 5'($urandom), 16'($urandom), 1'($urandom));
        finish_frame();
        wait_for_results();
    endtask

    task automatic run_random_frame();
        send_request(($urandom_range(1) == 0) ? CMD_READ : CMD_WRITE, 5'($urandom),
                     5'($urandom), 16'($urandom), 1'($urandom));
        while (frm_busy)
        begin
            if ($urandom_range(19) == 0)
                send_request(($urandom_range(1) == 0) ? CMD_READ : CMD_WRITE, 5'($urandom),
                             5'($urandom), 16'($urandom), 1'($urandom));
            else
                send_tick(($urandom_range(9) == 0) ? CMD_UNUSED : CMD_TICK);
        end
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
            send_tick(($urandom_range(1) == 0) ? CMD_UNUSED : CMD_TICK);
        if ($urandom_range(9) == 0)
            wait_for_results();
    endtask

    function automatic logic [PRE_W-1:0] pick_preamble();
        case ($urandom_range(9))
            6:       return 6'd32;
            7:       return 6'd63;
            8:       return 6'($urandom_range(33, 62));
            9:       return 6'($urandom_range(5, 31));
            default: return 6'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic test_random_traffic();
        int gap_by_phase[4]   = '{0, 56, 0, 33};
        int stall_by_phase[4] = '{0, 0, 56, 33};
        int target;
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_gap_pct = gap_by_phase[phase];
            stall_pct      = stall_by_phase[phase];
            target         = ok_requests + 240;
            while (ok_requests < target)
            begin
                if ($urandom_range(6) == 0)
                begin
                    wait_for_results();
                    set_preamble(pick_preamble());
                end
                run_random_frame();
            end
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_TICK;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pre_len        = PREAMBLE_RESET;
        frm_busy       = 1'b0;
        frm_read       = 1'b0;
        frm_pos        = '0;
        frm_shift      = '0;
        rd_capture     = '0;
        error_count    = 0;
        sender_gap_pct = 0;
        stall_pct      = 0;
        hold_left      = 0;
        ok_requests    = 0;
        reads_done     = 0;
        writes_done    = 0;
        refused_starts = 0;
        idle_ticks     = 0;
        results_checked = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_idle_commands();
        test_write_frame();
        test_read_frame();
        test_preamble_change();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        $display("Checked %0d results: %0d read and %0d write frames, %0d refused starts,",
                 results_checked, reads_done, writes_done, refused_starts);
        $display("%0d idle ticks, preamble lengths 0 to 63, stalls and a long hold-off",
                 idle_ticks);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mdiom_pkg.sv
hdl/mdiom_in_stage.sv
hdl/mdiom_frame_engine.sv
hdl/mdiom_out_stage.sv
hdl/mdio_management_frame_master.sv
test/mdio_management_frame_master_tb.sv
